### rtl/core/oets_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oets_pkg
// Shared widths, codes and constants of the one-euro track smoother.
// ---------------------------------------------------------------------------
package oets_pkg;

    localparam int ID_W  = 6;
    localparam int POS_W = 32;
    localparam int DT_W  = 16;
    localparam int CFG_W = 16;

    localparam int TRACK_SLOTS_DEF = 64;
    localparam int STALE_TICKS_DEF = 120;

    // opcodes of an input transaction
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TRACK = 1'b1;

    // register indexes (byte address bits [3:2])
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_SMOOTH_EN  = 2'd0;
    localparam logic [1:0] REG_MIN_CUTOFF = 2'd1;
    localparam logic [1:0] REG_BETA_GAIN  = 2'd2;
    localparam logic [1:0] REG_PRED_TIME  = 2'd3;

    localparam logic [CFG_W-1:0] MIN_CUTOFF_RST = 16'd256;
    localparam logic [DT_W-1:0]  DT_RST         = 16'd1;

    // 2*pi in Q16.16
    localparam int TWO_PI_INT = 411775;
    localparam logic [18:0] TWO_PI_Q16 = 19'(TWO_PI_INT);

    // derivative smoothing factor for the reset frame interval of one LSB
    localparam int ALPHA_D_RST_INT =
        ((TWO_PI_INT / 65536) * 65536) / ((TWO_PI_INT / 65536) + 65536);
    localparam logic [15:0] ALPHA_D_RST = 16'(ALPHA_D_RST_INT);

endpackage

### rtl/core/oets_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oets_in_if
// Input channel: begin-frame and track-sample transactions.
// ---------------------------------------------------------------------------
interface oets_in_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [oets_pkg::DT_W-1:0]        frame_dt;
    logic [oets_pkg::ID_W-1:0]        track_id;
    logic signed [oets_pkg::POS_W-1:0] pos_x;
    logic signed [oets_pkg::POS_W-1:0] pos_y;
    logic signed [oets_pkg::POS_W-1:0] vel_x;
    logic signed [oets_pkg::POS_W-1:0] vel_y;

    modport source (output valid, opcode, frame_dt, track_id, pos_x, pos_y, vel_x, vel_y,
                    input ready);
    modport sink   (input valid, opcode, frame_dt, track_id, pos_x, pos_y, vel_x, vel_y,
                    output ready);
endinterface

### rtl/core/oets_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oets_out_if
// Output channel: conditioned track positions.
// ---------------------------------------------------------------------------
interface oets_out_if;
    logic                             valid;
    logic                             ready;
    logic [oets_pkg::ID_W-1:0]        out_track_id;
    logic signed [oets_pkg::POS_W-1:0] out_x;
    logic signed [oets_pkg::POS_W-1:0] out_y;

    modport source (output valid, out_track_id, out_x, out_y, input ready);
    modport sink   (input valid, out_track_id, out_x, out_y, output ready);
endinterface

### rtl/core/oets_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oets_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module oets_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/one_euro_track_smoother_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// one_euro_track_smoother_top
// Per-track one-euro smoothing of 2-D positions with optional prediction.
// ---------------------------------------------------------------------------
// Usage:
//   i_in takes begin-frame transactions (opcode 0: latch frame_dt, advance
//   the tick, retire stale tracks) and track transactions (opcode 1). Each
//   track transaction gives one result on o_out; a begin frame gives none.
//   Registers sit on an APB port (pready tied high) and are to be written
//   only while the block is idle; the block itself does not enforce this.
//   One shared multiplier and one shared radix-2 divider do all the math
//   under a sequencer; i_in.ready is high only between items.
//   A filtered track sample runs two 48-step divisions for the raw
//   derivative and two 16-step divisions for the smoothing factor on the
//   divider; a bypassed, out-of-range or first sample skips the divider.
//   A begin frame runs one division for its derivative smoothing factor,
//   then a stale sweep over the last-seen memory.
//   A result waits in the output register while o_out.ready is low; the
//   next item can be taken meanwhile and stalls only at its own result.
//   Reset clears the registers to defaults, the tick, the frame interval
//   (to one) and all track valid bits.
// ---------------------------------------------------------------------------
module one_euro_track_smoother_top #(
    parameter int TRACK_SLOTS = oets_pkg::TRACK_SLOTS_DEF,
    parameter int STALE_TICKS = oets_pkg::STALE_TICKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    oets_in_if.sink                     i_in,
    oets_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [oets_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int IW  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int SWW = $clog2(TRACK_SLOTS + 1);
    localparam logic [31:0] STALE_LIM = 32'(STALE_TICKS) + 32'd1;
    localparam int SW_RAM = 128;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PRED_X, ST_PRED_Y, ST_PRED_DONE, ST_DECIDE,
        ST_DIFF, ST_DLD, ST_DDIV, ST_DDIFF, ST_SPD_MUL, ST_SPD_ADD, ST_MAG,
        ST_FC_MUL, ST_FC_ADD, ST_T_MUL, ST_W_MUL, ST_FR_MUL, ST_W,
        ST_ALD, ST_ADIV, ST_VAL_MUL, ST_VAL_ADD, ST_WB, ST_OUT, ST_SWEEP
    } t_state;

    t_state r_st;

    // configuration
    logic                        r_smooth_en;
    logic [oets_pkg::CFG_W-1:0]  r_min_cutoff;
    logic [oets_pkg::CFG_W-1:0]  r_beta_gain;
    logic [oets_pkg::CFG_W-1:0]  r_pred_time;

    // frame state
    logic [31:0]                 r_tick;
    logic [oets_pkg::DT_W-1:0]   r_dt;
    logic [15:0]                 r_alpha_d;
    logic [TRACK_SLOTS-1:0]      r_valid;

    // working registers of the current item
    logic                        r_frame;
    logic [oets_pkg::ID_W-1:0]   r_id;
    logic [IW-1:0]               r_slot;
    logic                        r_in_range;
    logic signed [31:0]          r_px, r_py, r_vx, r_vy;
    logic signed [31:0]          r_sm_x, r_sp_x, r_sm_y, r_sp_y;
    logic                        r_axis;
    logic signed [32:0]          r_diff;
    logic signed [31:0]          r_draw;
    logic signed [32:0]          r_t;
    logic [31:0]                 r_mag;
    logic [31:0]                 r_fc;
    logic [34:0]                 r_w;
    logic [15:0]                 r_alpha;

    // shared divider and multiplier
    logic [35:0]                 r_rem, r_dsr;
    logic [47:0]                 r_dvd, r_quo;
    logic [5:0]                  r_dcnt;
    logic signed [54:0]          r_prod;

    // stale sweep
    logic [SWW-1:0]              r_sw;
    logic [IW-1:0]               r_swp;
    logic                        r_swp_v;

    // output register
    logic                        r_ovalid;
    logic [oets_pkg::ID_W-1:0]   r_o_id;
    logic signed [31:0]          r_o_x, r_o_y;

    logic                        acc_in;
    logic                        sw_rd;
    logic                        st_we;
    logic [IW-1:0]               rd_addr;
    logic [31:0]                 last_rdata;
    logic [SW_RAM-1:0]           st_rdata;
    logic signed [34:0]          m_a;
    logic signed [19:0]          m_b;
    logic signed [54:0]          prod_sh16;
    logic signed [31:0]          pred_x, pred_y;
    logic signed [31:0]          cur_x, cur_val, cur_spd;
    logic [32:0]                 abs_diff;
    logic signed [31:0]          draw_val;
    logic [39:0]                 fc_sum;
    logic [36:0]                 rem2, rem_sub;
    logic                        div_ge;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign acc_in      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_st == ST_IDLE);
    assign sw_rd       = (r_st == ST_SWEEP) && (r_sw < SWW'(TRACK_SLOTS));
    assign st_we       = (r_st == ST_WB);
    assign rd_addr     = (r_st == ST_SWEEP) ? r_sw[IW-1:0] : IW'(i_in.track_id);

    assign o_out.valid        = r_ovalid;
    assign o_out.out_track_id = r_o_id;
    assign o_out.out_x        = r_o_x;
    assign o_out.out_y        = r_o_y;
    assign pready             = 1'b1;

    oets_ram #(.WIDTH(32), .DEPTH(TRACK_SLOTS)) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_slot),
        .i_wdata (r_tick),
        .i_re    (acc_in || sw_rd),
        .i_raddr (rd_addr),
        .o_rdata (last_rdata)
    );

    oets_ram #(.WIDTH(SW_RAM), .DEPTH(TRACK_SLOTS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_slot),
        .i_wdata ({r_sm_x, r_sp_x, r_sm_y, r_sp_y}),
        .i_re    (acc_in),
        .i_raddr (rd_addr),
        .o_rdata (st_rdata)
    );

    always_comb begin
        case (paddr[3:2])
            oets_pkg::REG_SMOOTH_EN:  prdata = {31'b0, r_smooth_en};
            oets_pkg::REG_MIN_CUTOFF: prdata = {16'b0, r_min_cutoff};
            oets_pkg::REG_BETA_GAIN:  prdata = {16'b0, r_beta_gain};
            oets_pkg::REG_PRED_TIME:  prdata = {16'b0, r_pred_time};
            default:                  prdata = 32'b0;
        endcase
    end

    // operand select of the shared multiplier
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_st)
            ST_PRED_X: begin
                m_a = 35'(r_vx);
                m_b = 20'({4'b0, r_pred_time});
            end
            ST_PRED_Y: begin
                m_a = 35'(r_vy);
                m_b = 20'({4'b0, r_pred_time});
            end
            ST_SPD_MUL: begin
                m_a = 35'(r_t);
                m_b = 20'({4'b0, r_alpha_d});
            end
            ST_FC_MUL: begin
                m_a = 35'({3'b0, r_mag});
                m_b = 20'({4'b0, r_beta_gain});
            end
            ST_T_MUL: begin
                m_a = 35'({3'b0, r_fc});
                m_b = 20'({4'b0, r_dt});
            end
            ST_W_MUL: begin
                m_a = 35'({3'b0, r_prod[47:16]});
                m_b = 20'({1'b0, oets_pkg::TWO_PI_Q16});
            end
            ST_FR_MUL: begin
                m_a = 35'({19'b0, r_dt});
                m_b = 20'({1'b0, oets_pkg::TWO_PI_Q16});
            end
            ST_VAL_MUL: begin
                m_a = 35'(r_diff);
                m_b = 20'({4'b0, r_alpha});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign prod_sh16 = r_prod >>> 16;
    assign pred_x    = sat32(34'(r_px) + 34'(prod_sh16[33:0]));
    assign pred_y    = sat32(34'(r_py) + 34'(prod_sh16[33:0]));

    assign cur_x   = r_axis ? r_py   : r_px;
    assign cur_val = r_axis ? r_sm_y : r_sm_x;
    assign cur_spd = r_axis ? r_sp_y : r_sp_x;

    assign abs_diff = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);

    // truncate toward zero, then saturate to 32 bits
    always_comb begin
        if (r_diff[32]) begin
            draw_val = (r_quo > 48'd2147483648) ? 32'sh80000000 : 32'(-r_quo[31:0]);
        end else begin
            draw_val = (r_quo > 48'd2147483647) ? 32'sh7fffffff : r_quo[31:0];
        end
    end

    assign fc_sum  = {16'b0, r_min_cutoff, 8'b0} + {1'b0, r_prod[46:8]};

    assign rem2    = {r_rem, r_dvd[47]};
    assign div_ge  = rem2 >= {1'b0, r_dsr};
    assign rem_sub = rem2 - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= ST_IDLE;
            r_smooth_en  <= 1'b1;
            r_min_cutoff <= oets_pkg::MIN_CUTOFF_RST;
            r_beta_gain  <= '0;
            r_pred_time  <= '0;
            r_tick       <= '0;
            r_dt         <= oets_pkg::DT_RST;
            r_alpha_d    <= oets_pkg::ALPHA_D_RST;
            r_valid      <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_prod <= m_a * m_b;

            // ST_OUT sets the output register itself
            if (o_out.ready && r_st != ST_OUT) begin
                r_ovalid <= 1'b0;
            end

            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    oets_pkg::REG_SMOOTH_EN:  r_smooth_en  <= pwdata[0];
                    oets_pkg::REG_MIN_CUTOFF: r_min_cutoff <= pwdata[15:0];
                    oets_pkg::REG_BETA_GAIN:  r_beta_gain  <= pwdata[15:0];
                    oets_pkg::REG_PRED_TIME:  r_pred_time  <= pwdata[15:0];
                    default: ;
                endcase
            end

            // divider step
            if ((r_st == ST_DDIV || r_st == ST_ADIV) && r_dcnt != 6'd0) begin
                r_rem  <= div_ge ? rem_sub[35:0] : rem2[35:0];
                r_dvd  <= {r_dvd[46:0], 1'b0};
                r_quo  <= {r_quo[46:0], div_ge};
                r_dcnt <= r_dcnt - 6'd1;
            end

            case (r_st)
                ST_IDLE: begin
                    if (acc_in) begin
                        r_id       <= i_in.track_id;
                        r_slot     <= IW'(i_in.track_id);
                        r_in_range <= (32'(i_in.track_id) < 32'(TRACK_SLOTS));
                        r_px       <= i_in.pos_x;
                        r_py       <= i_in.pos_y;
                        r_vx       <= i_in.vel_x;
                        r_vy       <= i_in.vel_y;
                        if (i_in.opcode == oets_pkg::OP_FRAME) begin
                            r_frame <= 1'b1;
                            r_dt    <= (i_in.frame_dt == '0) ? oets_pkg::DT_RST
                                                             : i_in.frame_dt;
                            r_tick  <= r_tick + 32'd1;
                            r_st    <= ST_FR_MUL;
                        end else begin
                            r_frame <= 1'b0;
                            r_st    <= ST_PRED_X;
                        end
                    end
                end
                ST_PRED_X: begin
                    r_sm_x <= st_rdata[127:96];
                    r_sp_x <= st_rdata[95:64];
                    r_sm_y <= st_rdata[63:32];
                    r_sp_y <= st_rdata[31:0];
                    r_st   <= ST_PRED_Y;
                end
                ST_PRED_Y: begin
                    if (r_pred_time != '0) begin
                        r_px <= pred_x;
                    end
                    r_st <= ST_PRED_DONE;
                end
                ST_PRED_DONE: begin
                    if (r_pred_time != '0) begin
                        r_py <= pred_y;
                    end
                    r_st <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (!r_smooth_en || !r_in_range) begin
                        r_sm_x <= r_px;
                        r_sm_y <= r_py;
                        r_st   <= ST_OUT;
                    end else if (!r_valid[r_slot]) begin
                        // first sample of the track: load the filter
                        r_sm_x          <= r_px;
                        r_sm_y          <= r_py;
                        r_sp_x          <= '0;
                        r_sp_y          <= '0;
                        r_valid[r_slot] <= 1'b1;
                        r_st            <= ST_WB;
                    end else begin
                        r_axis <= 1'b0;
                        r_st   <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_diff <= 33'(cur_x) - 33'(cur_val);
                    r_st   <= ST_DLD;
                end
                ST_DLD: begin
                    r_rem  <= '0;
                    r_dsr  <= {20'b0, r_dt};
                    r_dvd  <= {abs_diff[31:0], 16'b0};
                    r_quo  <= '0;
                    r_dcnt <= 6'd48;
                    r_st   <= ST_DDIV;
                end
                ST_DDIV: begin
                    if (r_dcnt == 6'd0) begin
                        r_draw <= draw_val;
                        r_st   <= ST_DDIFF;
                    end
                end
                ST_DDIFF: begin
                    r_t  <= 33'(r_draw) - 33'(cur_spd);
                    r_st <= ST_SPD_MUL;
                end
                ST_SPD_MUL: begin
                    r_st <= ST_SPD_ADD;
                end
                ST_SPD_ADD: begin
                    if (r_axis) begin
                        r_sp_y <= cur_spd + prod_sh16[31:0];
                    end else begin
                        r_sp_x <= cur_spd + prod_sh16[31:0];
                    end
                    r_st <= ST_MAG;
                end
                ST_MAG: begin
                    r_mag <= cur_spd[31] ? 32'(-cur_spd) : 32'(cur_spd);
                    r_st  <= ST_FC_MUL;
                end
                ST_FC_MUL: begin
                    r_st <= ST_FC_ADD;
                end
                ST_FC_ADD: begin
                    r_fc <= (fc_sum[39:32] != 8'd0) ? 32'hffffffff : fc_sum[31:0];
                    r_st <= ST_T_MUL;
                end
                ST_T_MUL: begin
                    r_st <= ST_W_MUL;
                end
                ST_W_MUL: begin
                    r_st <= ST_W;
                end
                ST_FR_MUL: begin
                    r_st <= ST_W;
                end
                ST_W: begin
                    r_w  <= r_prod[50:16];
                    r_st <= ST_ALD;
                end
                ST_ALD: begin
                    r_rem  <= {1'b0, r_w};
                    r_dsr  <= {1'b0, r_w} + 36'd65536;
                    r_dvd  <= '0;
                    r_quo  <= '0;
                    r_dcnt <= 6'd16;
                    r_st   <= ST_ADIV;
                end
                ST_ADIV: begin
                    if (r_dcnt == 6'd0) begin
                        if (r_frame) begin
                            r_alpha_d <= r_quo[15:0];
                            r_sw      <= '0;
                            r_swp_v   <= 1'b0;
                            r_st      <= ST_SWEEP;
                        end else begin
                            r_alpha <= r_quo[15:0];
                            r_st    <= ST_VAL_MUL;
                        end
                    end
                end
                ST_VAL_MUL: begin
                    r_st <= ST_VAL_ADD;
                end
                ST_VAL_ADD: begin
                    if (r_axis) begin
                        r_sm_y <= cur_val + prod_sh16[31:0];
                        r_st   <= ST_WB;
                    end else begin
                        r_sm_x <= cur_val + prod_sh16[31:0];
                        r_axis <= 1'b1;
                        r_st   <= ST_DIFF;
                    end
                end
                ST_WB: begin
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_o_id   <= r_id;
                        r_o_x    <= r_sm_x;
                        r_o_y    <= r_sm_y;
                        r_st     <= ST_IDLE;
                    end
                end
                ST_SWEEP: begin
                    // retire the slot whose last-seen tick arrived this cycle
                    if (r_swp_v && r_valid[r_swp] && ((r_tick - last_rdata) > STALE_LIM)) begin
                        r_valid[r_swp] <= 1'b0;
                    end
                    r_swp   <= r_sw[IW-1:0];
                    r_swp_v <= sw_rd;
                    r_sw    <= r_sw + SWW'(1);
                    if (r_sw == SWW'(TRACK_SLOTS)) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DDIV || r_st == ST_ADIV) |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_in.opcode == oets_pkg::OP_FRAME) |=> (r_tick == $past(r_tick) + 32'd1))
        else $error("tick did not advance on begin frame");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_SWEEP && r_st != ST_DECIDE) |=> $stable(r_valid))
        else $error("track valid bits changed outside sweep or load");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (r_in_range && r_smooth_en && !r_frame))
        else $error("filter memory written for a bypassed item");

endmodule
